FILE: design/deque_bulk_pop_engine_macros.svh
// assertion macros used by the deque engine control module
`ifndef DEQUE_BULK_POP_ENGINE_MACROS_SVH
`define DEQUE_BULK_POP_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DBPE_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dbpe assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DBPE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dbpe assertion failed");

`endif

FILE: design/dbpe_pkg.sv
// types and codes for the deque bulk pop engine
package dbpe_pkg;

    localparam int WORD_W  = 32;
    localparam int MODE_W  = 3;
    localparam int COUNT_W = 16;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_LEFT  = 3'd0,
        MODE_PUSH_RIGHT = 3'd1,
        MODE_POP_LEFT   = 3'd2,
        MODE_POP_RIGHT  = 3'd3,
        MODE_READ_OUT   = 3'd4
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_STREAM
    } state_t;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [WORD_W-1:0]  value;
        logic [COUNT_W-1:0]        count;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  data_word;
        logic                      is_data;
        logic                      last;
        logic [STAT_W-1:0]         status;
        logic [OCC_W-1:0]          occupancy;
    } out_item_t;

endpackage

FILE: design/dbpe_mem.sv
// word store: one write port, one read port with registered read data
module dbpe_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                               aclk,
    input  logic                               we,
    input  logic [AW-1:0]                      waddr,
    input  logic signed [dbpe_pkg::WORD_W-1:0] wdata,
    input  logic                               re,
    input  logic [AW-1:0]                      raddr,
    output logic signed [dbpe_pkg::WORD_W-1:0] rdata
);
    import dbpe_pkg::*;

    logic signed [WORD_W-1:0] store_mem [DEPTH];
    logic signed [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/dbpe_ctrl.sv
// command decode, ring pointers, read-out sequencer and output register
`include "deque_bulk_pop_engine_macros.svh"
module dbpe_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  dbpe_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output dbpe_pkg::out_item_t                m_data,
    output logic                               mem_we,
    output logic [AW-1:0]                      mem_waddr,
    output logic signed [dbpe_pkg::WORD_W-1:0] mem_wdata,
    output logic                               mem_re,
    output logic [AW-1:0]                      mem_raddr,
    input  logic signed [dbpe_pkg::WORD_W-1:0] mem_rdata
);
    import dbpe_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_reg, out_next;

    logic            out_free;
    logic            accept;
    logic            is_full;
    logic [AW-1:0]   head_dec;
    logic [AW-1:0]   rd_ptr_inc;
    logic [SW-1:0]   tail_sum;
    logic [AW-1:0]   tail_slot;
    logic [CW-1:0]   pop_n;
    logic [SW-1:0]   pop_sum;
    logic [AW-1:0]   pop_head;
    out_item_t       stat_item;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    assign is_full    = (fill_reg == CW'(DEPTH));
    assign head_dec   = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign rd_ptr_inc = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);

    // head + offset stays below twice the depth, so one subtract wraps it
    assign tail_sum  = SW'(head_reg) + SW'(fill_reg);
    assign tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

    assign pop_n    = (s_data.count < COUNT_W'(fill_reg)) ? CW'(s_data.count) : fill_reg;
    assign pop_sum  = SW'(head_reg) + SW'(pop_n);
    assign pop_head = (pop_sum >= SW'(DEPTH)) ? AW'(pop_sum - SW'(DEPTH)) : AW'(pop_sum);

    always_comb begin
        stat_item           = '0;
        stat_item.last      = 1'b1;
        stat_item.status    = STATUS_OK;
        stat_item.occupancy = OCC_W'(fill_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.mode == MODE_READ_OUT && fill_reg != '0) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_STREAM;
            end
            ST_STREAM: begin
                if (out_free && rem_reg == CW'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        head_next      = head_reg;
        fill_next      = fill_reg;
        rd_ptr_next    = rd_ptr_reg;
        rem_next       = rem_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        mem_we         = 1'b0;
        mem_waddr      = tail_slot;
        mem_wdata      = s_data.value;
        mem_re         = 1'b0;
        mem_raddr      = rd_ptr_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.mode)
                        MODE_PUSH_LEFT, MODE_PUSH_RIGHT: begin
                            out_valid_next = 1'b1;
                            out_next       = stat_item;
                            if (is_full) begin
                                out_next.status = STATUS_FULL;
                            end else begin
                                mem_we = 1'b1;
                                if (s_data.mode == MODE_PUSH_LEFT) begin
                                    mem_waddr = head_dec;
                                    head_next = head_dec;
                                end
                                fill_next          = fill_reg + CW'(1);
                                out_next.occupancy = OCC_W'(fill_reg + CW'(1));
                            end
                        end
                        MODE_POP_LEFT, MODE_POP_RIGHT: begin
                            out_valid_next     = 1'b1;
                            out_next           = stat_item;
                            fill_next          = fill_reg - pop_n;
                            out_next.occupancy = OCC_W'(fill_reg - pop_n);
                            if (s_data.mode == MODE_POP_LEFT) begin
                                head_next = pop_head;
                            end
                        end
                        MODE_READ_OUT: begin
                            if (fill_reg == '0) begin
                                out_valid_next  = 1'b1;
                                out_next        = stat_item;
                                out_next.status = STATUS_EMPTY;
                            end else begin
                                rd_ptr_next = head_reg;
                                rem_next    = fill_reg;
                            end
                        end
                        default: begin
                            // unknown commands are dropped without a result
                        end
                    endcase
                end
            end
            ST_READ: begin
                mem_re      = 1'b1;
                rd_ptr_next = rd_ptr_inc;
            end
            ST_STREAM: begin
                if (out_free) begin
                    out_valid_next     = 1'b1;
                    out_next.data_word = mem_rdata;
                    out_next.is_data   = 1'b1;
                    out_next.last      = (rem_reg == CW'(1));
                    out_next.status    = STATUS_OK;
                    out_next.occupancy = OCC_W'(fill_reg);
                    rem_next           = rem_reg - CW'(1);
                    // fetch the following word while this one goes out
                    if (rem_reg != CW'(1)) begin
                        mem_re      = 1'b1;
                        rd_ptr_next = rd_ptr_inc;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            rd_ptr_reg    <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            rd_ptr_reg    <= rd_ptr_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    `DBPE_ASSERT_SAME(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= CW'(DEPTH))
    `DBPE_ASSERT_SAME(a_rem_live, aclk, aresetn, state_reg != ST_IDLE, rem_reg != '0)
    `DBPE_ASSERT_NEXT(a_fill_hold, aclk, aresetn, state_reg != ST_IDLE, $stable(fill_reg))
    `DBPE_ASSERT_NEXT(a_last_ends, aclk, aresetn, state_reg == ST_STREAM && out_free && rem_reg == CW'(1), state_reg == ST_IDLE && m_valid && m_data.last)

endmodule

FILE: design/deque_bulk_pop_engine.sv
// push/pop: one command per cycle while output is free; status result registered
// read-out: a read state fetches the head word from the store's registered read port,
// then a word per cycle while output is free; input stalls until the last word is loaded
// full output register lets a new command in on the cycle its result is taken
// aresetn clears head, fill count and output valid; the word store keeps its contents
module deque_bulk_pop_engine #(
    parameter int DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dbpe_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dbpe_pkg::out_item_t m_data
);
    import dbpe_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [WORD_W-1:0] mem_wdata;
    logic                     mem_re;
    logic [AW-1:0]            mem_raddr;
    logic signed [WORD_W-1:0] mem_rdata;

    dbpe_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dbpe_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

FILE: sim/testbench.sv
// testbench for the deque bulk pop engine: directed and random commands checked against a predictor
`timescale 1ns / 1ps

module testbench;
    import dbpe_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int IN_W = $bits(in_item_t);
    localparam logic [MODE_W-1:0] FIRST_UNUSED_MODE = 3'd5;
    localparam logic [MODE_W-1:0] LAST_UNUSED_MODE  = 3'd7;

    // receiver stall styles
    localparam int RX_FREE    = 0;
    localparam int RX_COIN    = 1;
    localparam int RX_PATTERN = 2;
    localparam int RX_SPARSE  = 3;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // predictor state
    logic [WORD_W-1:0] deque_words [QUEUE_DEPTH];
    logic [5:0]        model_head = '0;
    logic [OCC_W-1:0]  model_fill = '0;
    out_item_t         pending_results [$];

    int unsigned mismatch_count = 0;
    int unsigned burst_left = 0;
    bit          gaps_enabled = 1'b0;
    int          rx_style = RX_FREE;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    logic [15:0] rx_pattern = 16'b1011_0011_1000_1101;

    deque_bulk_pop_engine #(.DEPTH(QUEUE_DEPTH)) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // appends one predicted result at the tail of the pending list
    function automatic void add_expected(input out_item_t res);
        pending_results.insert(pending_results.size(), res);
    endfunction

    // works out the results of one accepted command and updates the predicted deque
    function automatic void apply_command(input in_item_t cmd);
        out_item_t   res;
        logic [5:0]  slot;
        int unsigned removed;
        res = '0;
        res.last = 1'b1;
        res.status = STATUS_OK;
        case (cmd.mode)
            MODE_PUSH_LEFT, MODE_PUSH_RIGHT: begin
                if (model_fill == QUEUE_DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    if (cmd.mode == MODE_PUSH_LEFT) begin
                        model_head = model_head - 6'd1;
                        deque_words[model_head] = cmd.value;
                    end else begin
                        slot = model_head + model_fill[5:0];
                        deque_words[slot] = cmd.value;
                    end
                    model_fill = model_fill + 7'd1;
                end
                res.occupancy = model_fill;
                add_expected(res);
            end
            MODE_POP_LEFT, MODE_POP_RIGHT: begin
                removed = (cmd.count < model_fill) ? cmd.count : model_fill;
                if (cmd.mode == MODE_POP_LEFT) begin
                    model_head = model_head + removed[5:0];
                end
                model_fill = model_fill - removed[OCC_W-1:0];
                res.occupancy = model_fill;
                add_expected(res);
            end
            MODE_READ_OUT: begin
                if (model_fill == 0) begin
                    res.status = STATUS_EMPTY;
                    res.occupancy = '0;
                    add_expected(res);
                end else begin
                    for (int unsigned i = 0; i < model_fill; i++) begin
                        slot = model_head + i[5:0];
                        res.data_word = deque_words[slot];
                        res.is_data = 1'b1;
                        res.last = (i + 1 == model_fill);
                        res.occupancy = model_fill;
                        add_expected(res);
                    end
                end
            end
            default: begin
                // unused modes are dropped without a result
            end
        endcase
    endfunction

    function automatic in_item_t make_cmd(input logic [MODE_W-1:0] mode,
                                          input logic [WORD_W-1:0] value,
                                          input logic [COUNT_W-1:0] count);
        in_item_t cmd;
        cmd.mode = mode;
        cmd.value = value;
        cmd.count = count;
        return cmd;
    endfunction

    function automatic logic [MODE_W-1:0] any_push();
        return ($urandom_range(0, 1) != 0) ? MODE_PUSH_LEFT : MODE_PUSH_RIGHT;
    endfunction

    function automatic logic [MODE_W-1:0] any_pop();
        return ($urandom_range(0, 1) != 0) ? MODE_POP_LEFT : MODE_POP_RIGHT;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_pop_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return COUNT_W'($urandom_range(0, 65535));
            3, 4:    return COUNT_W'(model_fill + $urandom_range(0, 3));
            default: return COUNT_W'($urandom_range(0, 3));
        endcase
    endfunction

    // one transfer on the command channel, with random gaps between bursts when enabled
    task automatic send_command(input in_item_t cmd);
        int unsigned gap;
        if (gaps_enabled && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                s_data <= in_item_t'(IN_W'({$urandom, $urandom}));
                repeat (gap - 1) @(negedge aclk);
            end
        end
        if (burst_left != 0) begin
            burst_left--;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= cmd;
        do @(posedge aclk); while (!s_ready);
        apply_command(cmd);
    endtask

    task automatic note_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0s at %0t: expected data=%0d is_data=%0b last=%0b status=%0d occ=%0d",
                     what, $realtime, want.data_word, want.is_data, want.last,
                     want.status, want.occupancy);
            $display("    got data=%0d is_data=%0b last=%0b status=%0d occ=%0d",
                     got.data_word, got.is_data, got.last, got.status, got.occupancy);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", '0, m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data.data_word !== want.data_word || m_data.is_data !== want.is_data ||
                    m_data.last !== want.last || m_data.status !== want.status ||
                    m_data.occupancy !== want.occupancy) begin
                    note_mismatch("result mismatch", want, m_data);
                end
            end
        end
    end

    // receiver stalls, with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_style)
                RX_COIN:    m_ready <= ($urandom_range(0, 1) != 0);
                RX_PATTERN: m_ready <= rx_pattern[0];
                RX_SPARSE:  m_ready <= ($urandom_range(0, 3) == 0);
                default:    m_ready <= 1'b1;
            endcase
        end
    end

    task automatic test_empty_queue();
        rx_style = RX_FREE;
        gaps_enabled = 1'b0;
        send_command(make_cmd(MODE_READ_OUT, $urandom, COUNT_W'($urandom_range(0, 65535))));
        send_command(make_cmd(MODE_POP_LEFT, $urandom, '0));
        send_command(make_cmd(MODE_POP_RIGHT, $urandom, '1));
        for (int m = FIRST_UNUSED_MODE; m <= LAST_UNUSED_MODE; m++) begin
            send_command(make_cmd(MODE_W'(m), $urandom, COUNT_W'($urandom_range(0, 65535))));
        end
    endtask

    task automatic test_word_extremes();
        rx_style = RX_PATTERN;
        gaps_enabled = 1'b1;
        send_command(make_cmd(MODE_PUSH_LEFT, 32'h8000_0000, '0));
        send_command(make_cmd(MODE_PUSH_RIGHT, 32'h7FFF_FFFF, '1));
        send_command(make_cmd(MODE_PUSH_LEFT, 32'hFFFF_FFFF, '0));
        send_command(make_cmd(MODE_PUSH_RIGHT, 32'h0000_0000, '0));
        send_command(make_cmd(MODE_PUSH_LEFT, 32'h5555_5555, 16'h5555));
        send_command(make_cmd(MODE_PUSH_RIGHT, 32'hAAAA_AAAA, 16'hAAAA));
        send_command(make_cmd(MODE_READ_OUT, '0, '0));
        // zero-length removal leaves the queue alone
        send_command(make_cmd(MODE_POP_LEFT, '0, '0));
        send_command(make_cmd(MODE_POP_RIGHT, '0, 16'd1));
        send_command(make_cmd(MODE_POP_LEFT, '0, 16'd1));
        send_command(make_cmd(MODE_READ_OUT, '0, '0));
        // oversized removal empties it
        send_command(make_cmd(MODE_POP_RIGHT, '0, '1));
        send_command(make_cmd(MODE_READ_OUT, '0, '0));
    endtask

    task automatic test_full_queue();
        rx_style = RX_COIN;
        gaps_enabled = 1'b1;
        while (model_fill < QUEUE_DEPTH) begin
            send_command(make_cmd(any_push(), $urandom, COUNT_W'($urandom_range(0, 65535))));
        end
        send_command(make_cmd(MODE_PUSH_LEFT, $urandom, '0));
        send_command(make_cmd(MODE_PUSH_RIGHT, $urandom, '0));
        send_command(make_cmd(MODE_READ_OUT, '0, '0));
        send_command(make_cmd(MODE_POP_LEFT, '0, 16'd23));
        repeat (12) send_command(make_cmd(MODE_PUSH_LEFT, $urandom, '0));
        send_command(make_cmd(MODE_POP_RIGHT, '0, pick_pop_count()));
        send_command(make_cmd(MODE_READ_OUT, '0, '0));
        send_command(make_cmd(MODE_POP_LEFT, '0, 16'(QUEUE_DEPTH)));
    endtask

    // receiver holds off while commands keep coming, so the input must stall
    task automatic test_backpressure();
        rx_style = RX_FREE;
        gaps_enabled = 1'b0;
        hold_request = 300;
        repeat (12) send_command(make_cmd(any_push(), $urandom, '0));
        send_command(make_cmd(MODE_READ_OUT, '0, '0));
        repeat (8) send_command(make_cmd(any_push(), $urandom, '0));
        send_command(make_cmd(any_pop(), '0, 16'd5));
        send_command(make_cmd(MODE_READ_OUT, '0, '0));
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned done;
        int unsigned next_switch;
        int unsigned pick;
        done = 0;
        next_switch = 0;
        while (done < n_items) begin
            if (done >= next_switch) begin
                rx_style = $urandom_range(RX_FREE, RX_SPARSE);
                gaps_enabled = ($urandom_range(0, 3) != 0);
                next_switch = done + $urandom_range(20, 60);
            end
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                send_command(make_cmd(
                    MODE_W'($urandom_range(FIRST_UNUSED_MODE, LAST_UNUSED_MODE)),
                    $urandom, COUNT_W'($urandom_range(0, 65535))));
            end else if (pick < 8) begin
                // long push run, often into a full queue
                repeat ($urandom_range(8, 70)) begin
                    send_command(make_cmd(any_push(), $urandom,
                                          COUNT_W'($urandom_range(0, 65535))));
                    done++;
                end
            end else begin
                if (pick < 55) begin
                    send_command(make_cmd(any_push(), $urandom,
                                          COUNT_W'($urandom_range(0, 65535))));
                end else if (pick < 87) begin
                    send_command(make_cmd(any_pop(), $urandom, pick_pop_count()));
                end else begin
                    send_command(make_cmd(MODE_READ_OUT, $urandom,
                                          COUNT_W'($urandom_range(0, 65535))));
                end
                done++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_queue();
        test_word_extremes();
        test_full_queue();
        test_backpressure();
        test_random_traffic(240);

        @(negedge aclk);
        s_valid <= 1'b0;
        rx_style = RX_FREE;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (32) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
